>>> rtl/skde_pkg.sv
// ----------------------------------------------------------------------------
// skde_pkg
// Shared types and constants of the soft-knee downward expander.
// ----------------------------------------------------------------------------
package skde_pkg;

  localparam int SKDE_CHANNELS      = 8;
  localparam int SKDE_LEVEL_ENTRIES = 4096;
  localparam int SKDE_GAIN_ENTRIES  = 4096;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOPE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_KNEE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_KNEE  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MAKEUP    = 3'd6;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [23:0] band_sample;
  } skde_in_t;

  typedef struct packed {
    logic signed [23:0] scaled_sample;
    logic signed [15:0] gain_boost_db;
  } skde_out_t;

endpackage

>>> rtl/soft_knee_downward_expander.sv
// ----------------------------------------------------------------------------
// soft_knee_downward_expander
// Per-channel peak envelope, dB level lookup, soft-knee expansion gain and
// linear gain lookup, applied to one band sample.
// ----------------------------------------------------------------------------
// One word is worked through a single sequencer. The result register is loaded
// in the done state, after the envelope read-modify-write in the channel RAM,
// level ROM lookup, three knee multiplies, gain ROM lookup and final multiply,
// and the input opens again as it is loaded, so a word is taken only once the
// last one has left the sequencer. A word with a channel index at or beyond
// CHANNELS goes straight to the done state and reaches the result register
// with zeros, and the input opens again as it is loaded. The next word is taken
// while a finished result still waits in the output register; a second
// finished result then holds the sequencer in its last state until the
// output register is free. Envelope entries start at zero through
// per-channel valid bits; no clearing pass is needed after reset.
module soft_knee_downward_expander
  import skde_pkg::*;
#(
  parameter int CHANNELS         = SKDE_CHANNELS,
  parameter int LEVEL_TABLE_SIZE = SKDE_LEVEL_ENTRIES,
  parameter int GAIN_TABLE_SIZE  = SKDE_GAIN_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  skde_in_t               sample,
  output logic                   result_valid,
  input  logic                   result_ready,
  output skde_out_t              result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CH_AW = $clog2(CHANNELS > 1 ? CHANNELS : 2);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_ENV_MUL  = 4'd1;
  localparam logic [3:0] ST_ENV_UPD  = 4'd2;
  localparam logic [3:0] ST_LVL_MUL  = 4'd3;
  localparam logic [3:0] ST_LVL_IDX  = 4'd4;
  localparam logic [3:0] ST_LVL_RD   = 4'd5;
  localparam logic [3:0] ST_KNEE_MUL = 4'd6;
  localparam logic [3:0] ST_KNEE_SQ  = 4'd7;
  localparam logic [3:0] ST_KNEE_SCL = 4'd8;
  localparam logic [3:0] ST_BOOST    = 4'd9;
  localparam logic [3:0] ST_GAIN_MUL = 4'd10;
  localparam logic [3:0] ST_GAIN_IDX = 4'd11;
  localparam logic [3:0] ST_APPLY    = 4'd12;
  localparam logic [3:0] ST_DONE     = 4'd13;

  localparam logic [21:0]        DIV5_RECIP  = 22'd3355444;
  localparam logic signed [16:0] SLOPE_FLOOR = -17'sd3891;
  localparam logic [17:0]        LV_MAX      = 18'(LEVEL_TABLE_SIZE - 1);
  localparam logic [17:0]        GN_MAX      = 18'(GAIN_TABLE_SIZE - 1);
  localparam logic [15:0]        LEVEL_FLOOR = 16'(-30720);

  localparam longint unsigned DB_PER_OCTAVE_Q24   = 64'd101008905;
  localparam longint unsigned LOG2_10_OVER_20_Q32 = 64'd713378626;
  localparam longint unsigned LN2_Q32             = 64'd2977044472;

  // ---------------------------------------------------------------- tables
  function automatic longint rsr64(input longint v, input int s);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // restoring long division, used only while building the tables
  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    int              i;
    q = 64'd0;
    r = 64'd0;
    for (i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint log2_q16(input longint unsigned x);
    int unsigned     n;
    int unsigned     k;
    longint unsigned m;
    longint          r;
    n = 0;
    for (k = 1; k < 63; k++) begin
      if ((x >> k) != 0) n = k;
    end
    m = (n <= 30) ? (x << (30 - n)) : (x >> (n - 30));
    r = longint'(n) << 16;
    for (k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        r = r | (64'sd1 <<< (15 - k));
      end
    end
    return r;
  endfunction

  function automatic longint unsigned exp2_frac_q32(input longint unsigned f);
    longint unsigned t;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned n;
    t    = (f * LN2_Q32) >> 32;
    term = 64'd1 << 32;
    sum  = term;
    for (n = 1; n <= 20; n++) begin
      term = udiv64((term * t) >> 32, n);
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [15:0] level_entry(input int i);
    longint l;
    longint t;
    if (i == 0) return LEVEL_FLOOR;
    l = log2_q16(64'(i) * 64'd10) - log2_q16(64'(LEVEL_TABLE_SIZE));
    t = rsr64(l * longint'(DB_PER_OCTAVE_Q24), 32);
    if (t < -32768) t = -32768;
    if (t > 32767) t = 32767;
    return 16'(t);
  endfunction

  function automatic logic [15:0] gain_entry(input int i);
    longint unsigned sz;
    longint unsigned u;
    longint unsigned ep;
    longint unsigned s;
    longint unsigned g;
    int unsigned     ip;
    sz = 64'(GAIN_TABLE_SIZE);
    u  = 64'(i) * 64'd80 * LOG2_10_OVER_20_Q32 + ((64'd16 * sz) << 32)
         - 64'd60 * sz * LOG2_10_OVER_20_Q32;
    ep = udiv64(u, sz);
    ip = 32'(ep >> 32);
    s  = exp2_frac_q32(ep & 64'hFFFF_FFFF);
    g  = ((s << ip) + (64'd1 << 35)) >> 36;
    return (g > 64'd65535) ? 16'hFFFF : 16'(g);
  endfunction

  logic [15:0] level_tab [LEVEL_TABLE_SIZE];
  logic [15:0] gain_tab  [GAIN_TABLE_SIZE];

  for (genvar i = 0; i < LEVEL_TABLE_SIZE; i++) begin : g_level
    localparam logic [15:0] V = level_entry(i);
    assign level_tab[i] = V;
  end

  for (genvar i = 0; i < GAIN_TABLE_SIZE; i++) begin : g_gain
    localparam logic [15:0] V = gain_entry(i);
    assign gain_tab[i] = V;
  end

  // ---------------------------------------------------------------- helpers
  function automatic logic [17:0] div5(input logic [19:0] x);
    logic [41:0] p;
    p = 42'(x) * 42'(DIV5_RECIP);
    return p[41:24];
  endfunction

  function automatic logic signed [47:0] rsr48(input logic signed [47:0] v, input int sh);
    logic [47:0] m;
    m = v[47] ? 48'(-v) : 48'(v);
    m = (m + (48'd1 << (sh - 1))) >> sh;
    return v[47] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v < -48'sd32768) return -16'sd32768;
    if (v > 48'sd32767) return 16'sd32767;
    return 16'(v);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v < -48'sd8388608) return -24'sd8388608;
    if (v > 48'sd8388607) return 24'sd8388607;
    return 24'(v);
  endfunction

  // ---------------------------------------------------------------- config
  logic [15:0]        attack_coeff;
  logic [15:0]        release_coeff;
  logic signed [15:0] threshold_db;
  logic signed [16:0] slope;
  logic [12:0]        knee_half;
  logic [23:0]        inv_knee;
  logic signed [13:0] makeup_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coeff  <= 16'd65441;
      release_coeff <= 16'd65527;
      threshold_db  <= -16'sd10240;
      slope         <= 17'sd4096;
      knee_half     <= 13'd768;
      inv_knee      <= 24'd10923;
      makeup_gain   <= 14'sd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ATTACK:    attack_coeff  <= cfg_data[15:0];
        REG_RELEASE:   release_coeff <= cfg_data[15:0];
        REG_THRESHOLD: threshold_db  <= cfg_data[15:0];
        REG_SLOPE:     slope         <= cfg_data[16:0];
        REG_HALF_KNEE: knee_half     <= cfg_data[12:0];
        REG_INV_KNEE:  inv_knee      <= cfg_data[23:0];
        REG_MAKEUP:    makeup_gain   <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- envelope RAM
  logic [3:0]          st;
  logic [CH_AW-1:0]    ch_addr;
  logic [CH_AW-1:0]    ch_in_addr;
  logic [8:0]          ch_ext;
  logic                chan_bad;
  logic [CHANNELS-1:0] env_valid;
  logic                ram_we;
  logic [23:0]         ram_rdata;
  logic [23:0]         env_new;
  logic [41:0]         env_sum;

  assign ch_ext     = 9'(sample.channel);
  assign ch_in_addr = ch_ext[CH_AW-1:0];
  assign ram_we     = (st == ST_ENV_UPD);

  skde_ram #(
    .WIDTH (24),
    .DEPTH (CHANNELS)
  ) u_env_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_addr),
    .wdata (env_new),
    .raddr (ch_in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      env_valid <= '0;
    end else if (ram_we) begin
      env_valid[ch_addr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- datapath
  logic signed [23:0] smp;
  logic [20:0]        mag;
  logic [39:0]        p1;
  logic [37:0]        p2;
  logic [23:0]        env;
  logic [19:0]        lx;
  logic signed [15:0] level_q;
  logic signed [17:0] diff;
  logic signed [16:0] slc;
  logic               below;
  logic               above;
  logic [37:0]        pk;
  logic signed [34:0] bprod;
  logic signed [30:0] hs;
  logic [16:0]        rem2;
  logic signed [47:0] kprod;
  logic signed [15:0] boost;
  logic signed [16:0] gsum;
  logic               g_lo;
  logic               g_hi;
  logic [19:0]        gx;
  logic [15:0]        gain_q;
  logic signed [40:0] yprod;

  logic [23:0]        abs_in;
  logic [24:0]        mag_sum;
  logic [23:0]        env_cur;
  logic [15:0]        coeff;
  logic [40:0]        lprod;
  logic [17:0]        lq;
  logic [17:0]        lidx;
  logic signed [17:0] hk_s;
  logic signed [17:0] dh;
  logic [29:0]        pfrac;
  logic [16:0]        pcl;
  logic [16:0]        rem;
  logic [33:0]        rsq;
  logic signed [47:0] b_raw;
  logic signed [15:0] boost_c;
  logic signed [16:0] goff;
  logic [31:0]        gprod;
  logic [17:0]        gq;
  logic [17:0]        gidx;

  assign abs_in  = sample.band_sample[23] ? 24'(-sample.band_sample)
                                          : 24'(sample.band_sample);
  assign mag_sum = 25'(abs_in) + 25'd4;

  assign env_cur = env_valid[ch_addr] ? ram_rdata : 24'd0;
  assign coeff   = ({3'b000, mag} > env_cur) ? attack_coeff : release_coeff;

  assign env_sum = 42'(p1) + 42'(p2) + 42'd32768;
  assign env_new = (env_sum[39:16] == 24'd0) ? 24'd1 : env_sum[39:16];

  assign lprod = 41'(env) * 41'(LEVEL_TABLE_SIZE);
  assign lq    = div5(lx);
  assign lidx  = (lq > LV_MAX) ? LV_MAX : lq;

  assign hk_s = $signed({5'b00000, knee_half});
  assign dh   = diff + hk_s;

  assign pfrac = pk[37:8];
  assign pcl   = (pfrac > 30'd65536) ? 17'h10000 : pfrac[16:0];
  assign rem   = 17'h10000 - pcl;
  assign rsq   = 34'(rem) * 34'(rem);

  always_comb begin
    if (below) begin
      b_raw = rsr48(48'(bprod), 12);
    end else if (above) begin
      b_raw = '0;
    end else begin
      b_raw = rsr48(kprod, 28);
    end
  end
  assign boost_c = sat16(b_raw);

  assign goff  = gsum + 17'sd15360;
  assign gprod = 32'(goff[14:0]) * 32'(GAIN_TABLE_SIZE);
  assign gq    = div5(gx);

  always_comb begin
    if (g_lo) begin
      gidx = '0;
    end else if (g_hi || (gq > GN_MAX)) begin
      gidx = GN_MAX;
    end else begin
      gidx = gq;
    end
  end

  assign sample_ready = (st == ST_IDLE);

  always_ff @(posedge clk) begin
    unique case (st)
      ST_IDLE: begin
        smp      <= sample.band_sample;
        mag      <= mag_sum[23:3];
        ch_addr  <= ch_in_addr;
        chan_bad <= ({29'd0, sample.channel} >= 32'(CHANNELS));
      end
      ST_ENV_MUL: begin
        p1 <= 40'(env_cur) * 40'(coeff);
        p2 <= 38'(mag) * 38'(17'h10000 - 17'(coeff));
      end
      ST_ENV_UPD: begin
        env <= env_new;
      end
      ST_LVL_MUL: begin
        lx <= lprod[40:21];
      end
      ST_LVL_IDX: begin
        level_q <= level_tab[lidx[$clog2(LEVEL_TABLE_SIZE)-1:0]];
      end
      ST_LVL_RD: begin
        diff <= 18'(level_q) - 18'(threshold_db);
        slc  <= (slope < SLOPE_FLOOR) ? SLOPE_FLOOR : slope;
      end
      ST_KNEE_MUL: begin
        below <= (diff <= -hk_s);
        above <= (diff >= hk_s);
        pk    <= 38'(dh[13:0]) * 38'(inv_knee);
        bprod <= 35'(diff) * 35'(slc);
        hs    <= -(31'($signed({1'b0, knee_half})) * 31'(slc));
      end
      ST_KNEE_SQ: begin
        rem2 <= rsq[32:16];
      end
      ST_KNEE_SCL: begin
        kprod <= 48'(hs) * 48'($signed({1'b0, rem2}));
      end
      ST_BOOST: begin
        boost <= boost_c;
        gsum  <= 17'(makeup_gain) + 17'(boost_c);
      end
      ST_GAIN_MUL: begin
        g_lo <= (gsum <= -17'sd15360);
        g_hi <= (gsum >= 17'sd5120);
        gx   <= gprod[31:12];
      end
      ST_GAIN_IDX: begin
        gain_q <= gain_tab[gidx[$clog2(GAIN_TABLE_SIZE)-1:0]];
      end
      ST_APPLY: begin
        yprod <= 41'(smp) * 41'($signed({1'b0, gain_q}));
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  logic done_fire;
  assign done_fire = (st == ST_DONE) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (sample_valid) begin
            st <= ({29'd0, sample.channel} >= 32'(CHANNELS)) ? ST_DONE : ST_ENV_MUL;
          end
        end
        ST_ENV_MUL:  st <= ST_ENV_UPD;
        ST_ENV_UPD:  st <= ST_LVL_MUL;
        ST_LVL_MUL:  st <= ST_LVL_IDX;
        ST_LVL_IDX:  st <= ST_LVL_RD;
        ST_LVL_RD:   st <= ST_KNEE_MUL;
        ST_KNEE_MUL: st <= ST_KNEE_SQ;
        ST_KNEE_SQ:  st <= ST_KNEE_SCL;
        ST_KNEE_SCL: st <= ST_BOOST;
        ST_BOOST:    st <= ST_GAIN_MUL;
        ST_GAIN_MUL: st <= ST_GAIN_IDX;
        ST_GAIN_IDX: st <= ST_APPLY;
        ST_APPLY:    st <= ST_DONE;
        ST_DONE: begin
          if (done_fire) st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      result.scaled_sample <= chan_bad ? 24'sd0 : sat24(rsr48(48'(yprod), 12));
      result.gain_boost_db <= chan_bad ? 16'sd0 : boost;
    end
  end

endmodule

>>> rtl/skde_ram.sv
// ----------------------------------------------------------------------------
// skde_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module skde_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/skde_check.sv
// ----------------------------------------------------------------------------
// skde_check
// Port-level checks of the soft-knee downward expander, bound to the top.
// ----------------------------------------------------------------------------
module skde_check
  import skde_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      sample_valid,
  input logic      sample_ready,
  input logic      result_valid,
  input logic      result_ready,
  input skde_out_t result
);

  // words taken but not yet delivered
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      case ({sample_valid && sample_ready, result_valid && result_ready})
        2'b10:   pending <= pending + 2'd1;
        2'b01:   pending <= pending - 2'd1;
        default: pending <= pending;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("second word taken while one is in work");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 2'd0)
    else $error("result without a pending word");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two words in flight");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind soft_knee_downward_expander skde_check u_skde_check (.*);
